// ----- rtl/core/hgh_pff_pkg.sv -----
// ----------------------------------------------------------------------------
// hgh_pff_pkg
// types, constants and tables shared by the projector form factor core
// ----------------------------------------------------------------------------
`default_nettype none

package hgh_pff_pkg;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_UNTAB = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam int IN_W  = 96;
  localparam int OUT_W = 40;

  localparam logic [35:0] HALF_LOG2E = 36'd12102203;
  localparam logic [35:0] LN2        = 36'd11629080;
  localparam logic [35:0] PREF       = 36'd19794854;

  typedef enum logic [3:0] {
    OP_X, OP_X2, OP_T, OP_U, OP_UU, OP_G, OP_X4, OP_POLY, OP_W,
    OP_E, OP_PG, OP_R2, OP_R3, OP_FAC, OP_FF
  } op_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_LOAD, CS_LO, CS_HI, CS_WB, CS_SQRT, CS_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    FIN_EARLY, FIN_ZERO, FIN_CALC
  } fin_t;

  typedef struct packed {
    logic       accept;
    op_t        op;
    logic [1:0] term;
    logic       mul_load;
    logic       mul_lo;
    logic       mul_hi;
    logic       wb;
    logic       sqrt_step;
    logic       fin;
    fin_t       fin_kind;
  } pff_cmd_t;

  typedef struct packed {
    logic       early;
    logic [1:0] cnt;
    logic [1:0] chan;
    logic       wb_under;
    logic       wb_gzero;
    logic       sqrt_last;
    logic       out_free;
  } pff_stat_t;

  function automatic logic [35:0] coef(input logic [1:0] l, input logic [1:0] i);
    logic [35:0] c;
    c = 36'd49009385;
    case (l)
      2'd0: begin
        case (i)
          2'd0:    c = 36'd94906266;
          2'd1:    c = 36'd49009385;
          default: c = 36'd12349204;
        endcase
      end
      2'd1: begin
        c = (i == 2'd0) ? 36'd77490641 : 36'd26196618;
      end
      default: c = 36'd49009385;
    endcase
    return c;
  endfunction

  function automatic logic [35:0] exp2_frac(input logic [3:0] k);
    logic [35:0] v;
    case (k)
      4'd0:    v = 36'd16777216;
      4'd1:    v = 36'd16065917;
      4'd2:    v = 36'd15384775;
      4'd3:    v = 36'd14732511;
      4'd4:    v = 36'd14107901;
      4'd5:    v = 36'd13509772;
      4'd6:    v = 36'd12937002;
      4'd7:    v = 36'd12388516;
      4'd8:    v = 36'd11863283;
      4'd9:    v = 36'd11360319;
      4'd10:   v = 36'd10878679;
      4'd11:   v = 36'd10417458;
      4'd12:   v = 36'd9975792;
      4'd13:   v = 36'd9552851;
      4'd14:   v = 36'd9147842;
      default: v = 36'd8760003;
    endcase
    return v;
  endfunction

  function automatic logic [35:0] abs38(input logic signed [37:0] v);
    logic [37:0] m;
    m = v[37] ? 38'(-v) : 38'(v);
    return m[35:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hgh_pff_ctrl.sv -----
// ----------------------------------------------------------------------------
// hgh_pff_ctrl
// sequencer that steps the shared multiplier and square root through one item
// ----------------------------------------------------------------------------
`default_nettype none

module hgh_pff_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  hgh_pff_pkg::pff_stat_t stat,
  output hgh_pff_pkg::pff_cmd_t  cmd
);
  import hgh_pff_pkg::*;

  ctrl_state_t state, state_next;
  op_t         op, op_next;
  logic [1:0]  term, term_next;
  fin_t        fin_kind, fin_kind_next;
  logic        last_term;

  assign last_term = (term == 2'(stat.cnt - 2'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CS_IDLE;
      op       <= OP_X;
      term     <= 2'd0;
      fin_kind <= FIN_ZERO;
    end else begin
      state    <= state_next;
      op       <= op_next;
      term     <= term_next;
      fin_kind <= fin_kind_next;
    end
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    term_next     = term;
    fin_kind_next = fin_kind;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.op        = op;
    cmd.term      = term;
    cmd.fin_kind  = fin_kind;
    case (state)
      CS_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          op_next   = OP_X;
          term_next = 2'd0;
          if (stat.early) begin
            fin_kind_next = FIN_EARLY;
            state_next    = CS_DONE;
          end else begin
            state_next = CS_LOAD;
          end
        end
      end
      CS_LOAD: begin
        cmd.mul_load = 1'b1;
        state_next   = CS_LO;
      end
      CS_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = CS_HI;
      end
      CS_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = CS_WB;
      end
      CS_WB: begin
        cmd.wb     = 1'b1;
        state_next = CS_LOAD;
        case (op)
          OP_X:  op_next = OP_X2;
          OP_X2: op_next = OP_T;
          OP_T: begin
            if (stat.wb_under) begin
              fin_kind_next = FIN_ZERO;
              state_next    = CS_DONE;
            end else begin
              op_next = OP_U;
            end
          end
          OP_U:  op_next = OP_UU;
          OP_UU: op_next = OP_G;
          OP_G: begin
            if (stat.wb_gzero) begin
              fin_kind_next = FIN_ZERO;
              state_next    = CS_DONE;
            end else begin
              op_next = OP_X4;
            end
          end
          OP_X4:   op_next = OP_POLY;
          OP_POLY: op_next = OP_W;
          OP_W: begin
            if (last_term) begin
              op_next = (stat.chan == 2'd0) ? OP_PG : OP_E;
            end else begin
              term_next = 2'(term + 2'd1);
              op_next   = OP_POLY;
            end
          end
          OP_E:  op_next = OP_PG;
          OP_PG: op_next = OP_R2;
          OP_R2: op_next = OP_R3;
          OP_R3: begin
            op_next    = OP_FAC;
            state_next = CS_SQRT;
          end
          OP_FAC: op_next = OP_FF;
          OP_FF: begin
            fin_kind_next = FIN_CALC;
            state_next    = CS_DONE;
          end
          default: state_next = CS_IDLE;
        endcase
      end
      CS_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) state_next = CS_LOAD;
      end
      CS_DONE: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/hgh_pff_dp.sv -----
// ----------------------------------------------------------------------------
// hgh_pff_dp
// operand registers, shared 18x36 multiplier, square root and result register
// ----------------------------------------------------------------------------
`default_nettype none

module hgh_pff_dp #(
  parameter int MAX_TERMS = 3
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  [hgh_pff_pkg::IN_W-1:0]       s_tdata,
  output logic [hgh_pff_pkg::OUT_W-1:0]      m_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  input  hgh_pff_pkg::pff_cmd_t              cmd,
  output hgh_pff_pkg::pff_stat_t             stat
);
  import hgh_pff_pkg::*;

  logic [19:0]        q;
  logic [1:0]         chan;
  logic [17:0]        r;
  logic [1:0]         cnt;
  logic signed [17:0] w0, w1, w2;
  logic               bad;

  logic [29:0]        x;
  logic [35:0]        x2, t, x4;
  logic [19:0]        u;
  logic [24:0]        p, g;
  logic signed [37:0] pt, s, e, pg;
  logic [35:0]        rr;
  logic [27:0]        fac;
  logic [54:0]        sq_v, sq_res, sq_bit, sq_sum;
  logic [31:0]        ff;
  logic               sat;

  logic [35:0]        mul_a, mul_b, a_sel, b_sel;
  logic               mul_neg, neg_sel;
  logic [71:0]        acc;
  logic [17:0]        half;
  logic [53:0]        pp;

  logic               out_valid;
  logic [31:0]        out_ff;
  logic [1:0]         out_status;

  logic [1:0]         in_cnt, in_chan, ntab;
  logic signed [17:0] w_sel;
  logic [17:0]        w_mag;
  logic signed [37:0] one, x2s, x4s, arg, e_src;
  logic [4:0]         n;
  logic [24:0]        g_calc;
  logic [37:0]        mag24, mag16;
  logic signed [37:0] sres, sres16;
  logic [47:0]        ff_mag;
  logic [31:0]        ff_calc;
  logic               ff_sat;

  // input field split
  assign in_chan = s_tdata[21:20];
  assign in_cnt  = s_tdata[41:40];

  always_comb begin
    case (in_chan)
      2'd0:    ntab = 2'd3;
      2'd1:    ntab = 2'd2;
      2'd2:    ntab = 2'd1;
      default: ntab = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q    <= s_tdata[19:0];
      chan <= in_chan;
      r    <= s_tdata[39:22];
      cnt  <= in_cnt;
      w0   <= s_tdata[59:42];
      w1   <= s_tdata[77:60];
      w2   <= s_tdata[95:78];
      bad  <= (int'(in_cnt) > MAX_TERMS) || (in_cnt > ntab);
    end
  end

  // operand select
  always_comb begin
    case (cmd.term)
      2'd0:    w_sel = w0;
      2'd1:    w_sel = w1;
      default: w_sel = w2;
    endcase
    w_mag = w_sel[17] ? 18'(-w_sel) : 18'(w_sel);
    one   = 38'sd16777216;
    x2s   = signed'({2'b00, x2});
    x4s   = signed'({2'b00, x4});
    arg   = one;
    case (chan)
      2'd0: begin
        case (cmd.term)
          2'd0:    arg = one;
          2'd1:    arg = 38'(38'sd3 * one - x2s);
          default: arg = 38'(38'sd15 * one - 38'sd10 * x2s + x4s);
        endcase
      end
      2'd1: begin
        arg = (cmd.term == 2'd0) ? one : 38'(38'sd5 * one - x2s);
      end
      default: arg = one;
    endcase
    e_src = (chan == 2'd0) ? s : e;

    a_sel   = '0;
    b_sel   = '0;
    neg_sel = 1'b0;
    case (cmd.op)
      OP_X: begin
        a_sel = 36'(q);
        b_sel = 36'(r);
      end
      OP_X2: begin
        a_sel = 36'(x);
        b_sel = 36'(x);
      end
      OP_T: begin
        a_sel = x2;
        b_sel = HALF_LOG2E;
      end
      OP_U: begin
        a_sel = 36'(t[19:0]);
        b_sel = LN2;
      end
      OP_UU: begin
        a_sel = 36'(u);
        b_sel = 36'(u);
      end
      OP_G: begin
        a_sel = exp2_frac(t[23:20]);
        b_sel = 36'(p);
      end
      OP_X4: begin
        a_sel = x2;
        b_sel = x2;
      end
      OP_POLY: begin
        a_sel   = coef(chan, cmd.term);
        b_sel   = abs38(arg);
        neg_sel = arg[37];
      end
      OP_W: begin
        a_sel   = abs38(pt);
        b_sel   = 36'(w_mag);
        neg_sel = pt[37] ^ w_sel[17];
      end
      OP_E: begin
        a_sel   = abs38(s);
        b_sel   = (chan == 2'd1) ? 36'(x) : x2;
        neg_sel = s[37];
      end
      OP_PG: begin
        a_sel   = abs38(e_src);
        b_sel   = 36'(g);
        neg_sel = e_src[37];
      end
      OP_R2: begin
        a_sel = 36'(r);
        b_sel = 36'(r);
      end
      OP_R3: begin
        a_sel = rr;
        b_sel = 36'(r);
      end
      OP_FAC: begin
        a_sel = PREF;
        b_sel = 36'(sq_res[26:0]);
      end
      OP_FF: begin
        a_sel   = abs38(pg);
        b_sel   = 36'(fac);
        neg_sel = pg[37];
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  // shared multiplier, low half of a then high half
  assign half = cmd.mul_hi ? mul_a[35:18] : mul_a[17:0];
  assign pp   = half * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_a   <= a_sel;
      mul_b   <= b_sel;
      mul_neg <= neg_sel;
    end
    if (cmd.mul_lo) acc <= {18'b0, pp};
    if (cmd.mul_hi) acc <= acc + {pp, 18'b0};
  end

  // write-back shaping
  assign n       = t[28:24];
  assign g_calc  = acc[48:24] >> n;
  assign mag24   = {2'b00, acc[59:24]};
  assign mag16   = {2'b00, acc[51:16]};
  assign sres    = mul_neg ? signed'(38'(-mag24)) : signed'(mag24);
  assign sres16  = mul_neg ? signed'(38'(-mag16)) : signed'(mag16);
  assign ff_mag  = acc[71:24];

  always_comb begin
    ff_sat  = 1'b0;
    ff_calc = ff_mag[31:0];
    if (mul_neg) begin
      if (ff_mag > 48'h80000000) begin
        ff_sat  = 1'b1;
        ff_calc = 32'h80000000;
      end else begin
        ff_calc = 32'(-ff_mag[31:0]);
      end
    end else if (ff_mag > 48'h7fffffff) begin
      ff_sat  = 1'b1;
      ff_calc = 32'h7fffffff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) s <= '0;
    if (cmd.wb) begin
      case (cmd.op)
        OP_X:    x  <= acc[37:8];
        OP_X2:   x2 <= acc[59:24];
        OP_T:    t  <= acc[59:24];
        OP_U:    u  <= acc[43:24];
        OP_UU:   p  <= 25'(25'h1000000 - 25'(u) + 25'(acc[44:25]));
        OP_G:    g  <= g_calc;
        OP_X4:   x4 <= acc[59:24];
        OP_POLY: pt <= sres;
        OP_W:    s  <= 38'(s + sres16);
        OP_E:    e  <= sres;
        OP_PG:   pg <= sres;
        OP_R2:   rr <= acc[35:0];
        OP_R3: begin
          sq_v   <= {1'b0, acc[53:0]};
          sq_res <= '0;
          sq_bit <= 55'(1) << 52;
        end
        OP_FAC:  fac <= acc[51:24];
        OP_FF: begin
          ff  <= ff_calc;
          sat <= ff_sat;
        end
        default: x <= x;
      endcase
    end
    if (cmd.sqrt_step) begin
      if (sq_v >= sq_sum) begin
        sq_v   <= sq_v - sq_sum;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  assign sq_sum = sq_res + sq_bit;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      case (cmd.fin_kind)
        FIN_EARLY: begin
          out_ff     <= '0;
          out_status <= bad ? STATUS_UNTAB : STATUS_OK;
        end
        FIN_CALC: begin
          out_ff     <= ff;
          out_status <= sat ? STATUS_SAT : STATUS_OK;
        end
        default: begin
          out_ff     <= '0;
          out_status <= STATUS_OK;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_status, out_ff};

  always_comb begin
    stat.early     = (int'(in_cnt) > MAX_TERMS) || (in_cnt > ntab) || (in_cnt == 2'd0);
    stat.cnt       = cnt;
    stat.chan      = chan;
    stat.wb_under  = (acc[59:48] >= 12'd24);
    stat.wb_gzero  = (g_calc == 25'd0);
    stat.sqrt_last = sq_bit[0];
    stat.out_free  = !out_valid || m_tready;
  end

endmodule

`default_nettype wire

// ----- rtl/core/hgh_projector_form_factor_core.sv -----
// ----------------------------------------------------------------------------
// hgh_projector_form_factor_core
// reciprocal-space form factor of one diagonalised projector per input word
// ----------------------------------------------------------------------------
// One input word gives one output word. A word is worked on alone: every
// product goes through one shared 18x36 multiplier in two passes plus an
// operand load and a write-back, for each of the 14 to 18 products, and the
// floor square root of r^3 takes 27 one-bit steps. Words that are
// untabulated or have no terms skip the arithmetic and go straight to the
// result, and words whose gaussian underflows stop after the T or G
// write-back. The output register lets the next word be accepted while a
// result still waits.
`default_nettype none

module hgh_projector_form_factor_core #(
  parameter int MAX_TERMS = 3
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // momentum, channel, radius, term_count, weight_0, weight_1, weight_2
  input  wire  [95:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // form_factor, status, zero fill
  output logic [39:0] m_tdata
);
  import hgh_pff_pkg::*;

  pff_cmd_t  cmd;
  pff_stat_t stat;

  hgh_pff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hgh_pff_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

// ----- rtl/core/hgh_pff_checker.sv -----
// ----------------------------------------------------------------------------
// hgh_pff_checker
// port-level checks of the form factor core
// ----------------------------------------------------------------------------
`default_nettype none

module hgh_pff_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [39:0] m_tdata
);
  import hgh_pff_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_untab_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] == STATUS_UNTAB |-> m_tdata[31:0] == 32'h0)
    else $error("untabulated word with nonzero form factor");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] == STATUS_SAT |->
      m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000)
    else $error("saturated word not at a bound");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_accept_not_done: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken before the first finished");

endmodule

bind hgh_projector_form_factor_core hgh_pff_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// projector form factor core: streams directed and random projector words
// through the core under varied sender and receiver stalls and checks each
// result word against a bit-accurate fixed-point model of beta(q)
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import hgh_pff_pkg::*;

  localparam int TERMS_MAX = 3;
  localparam longint unsigned SAT_LIMIT = 64'd1 << 60;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  logic [95:0] word_queue[$];
  logic [33:0] ff_expected[$];
  int          num_items;
  int          num_sent = 0;
  int          num_errors = 0;
  int          cycle = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  hgh_projector_form_factor_core #(.MAX_TERMS(TERMS_MAX)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint fx_mul(input longint a, input longint b, input int sh,
                                    inout bit sat);
    longint unsigned ua, ub, m;
    logic [127:0] prod;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    prod = 128'(ua) * 128'(ub);
    if (prod[127:64] != 0) begin
      m = SAT_LIMIT;
      sat = 1'b1;
    end else begin
      m = prod[63:0] >> sh;
      if (m > SAT_LIMIT) begin
        m = SAT_LIMIT;
        sat = 1'b1;
      end
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint poly_value(input int l, input int i, input longint x2,
                                        input longint x4, inout bit sat);
    longint one;
    one = 64'sd1 << 24;
    if (l == 0) begin
      if (i == 0) return longint'(coef(2'd0, 2'd0));
      if (i == 1) return fx_mul(longint'(coef(2'd0, 2'd1)), 3 * one - x2, 24, sat);
      return fx_mul(longint'(coef(2'd0, 2'd2)), 15 * one - 10 * x2 + x4, 24, sat);
    end
    if (l == 1) begin
      if (i == 0) return longint'(coef(2'd1, 2'd0));
      return fx_mul(longint'(coef(2'd1, 2'd1)), 5 * one - x2, 24, sat);
    end
    return longint'(coef(2'd2, 2'd0));
  endfunction

  // returns {status, form_factor}
  function automatic logic [33:0] form_factor_of(input logic [95:0] w);
    longint unsigned q, r, x, x2, t, n, g, f, rest, u, p;
    longint s, e, pg, fac, ff, wt;
    int l, cnt;
    logic [1:0] status;
    bit sat;
    q = w[19:0];
    l = w[21:20];
    r = w[39:22];
    cnt = w[41:40];
    status = STATUS_OK;
    ff = 0;
    sat = 1'b0;
    if (cnt > TERMS_MAX) status = STATUS_UNTAB;
    for (int i = 0; i < cnt; i++)
      if (!((l == 0 && i < 3) || (l == 1 && i < 2) || (l == 2 && i < 1)))
        status = STATUS_UNTAB;
    if (status == STATUS_OK && cnt > 0) begin
      x = (q * r) >> 8;
      x2 = (x * x) >> 24;
      t = (x2 * longint'(HALF_LOG2E)) >> 24;
      n = t >> 24;
      g = 0;
      if (n < 24) begin
        f = t & 64'hFFFFFF;
        rest = f & 64'hFFFFF;
        u = (rest * longint'(LN2)) >> 24;
        p = (64'd1 << 24) - u + ((u * u) >> 25);
        g = ((longint'(exp2_frac(4'(f >> 20))) * p) >> 24) >> n;
      end
      if (g != 0) begin
        s = 0;
        for (int i = 0; i < cnt; i++) begin
          wt = longint'($signed(w[42 + 18 * i +: 18]));
          s += fx_mul(poly_value(l, i, longint'(x2), longint'((x2 * x2) >> 24), sat),
                      wt, 16, sat);
        end
        if (l == 1) e = fx_mul(s, longint'(x), 24, sat);
        else if (l == 2) e = fx_mul(s, longint'(x2), 24, sat);
        else e = s;
        pg = fx_mul(e, longint'(g), 24, sat);
        fac = longint'((longint'(PREF) * root_floor(r * r * r)) >> 24);
        ff = fx_mul(pg, fac, 24, sat);
        if (ff > 64'sd2147483647) begin
          ff = 64'sd2147483647;
          sat = 1'b1;
        end
        if (ff < -64'sd2147483648) begin
          ff = -64'sd2147483648;
          sat = 1'b1;
        end
        if (sat) status = STATUS_SAT;
      end
    end
    return {status, ff[31:0]};
  endfunction

  task automatic add_word(input int q, input int l, input int r, input int cnt,
                          input int w0, input int w1, input int w2);
    word_queue.insert(word_queue.size(),
                      {18'(w2), 18'(w1), 18'(w0), 2'(cnt), 18'(r), 2'(l), 20'(q)});
  endtask

  function automatic int rand_weight();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 262143));
    return int'($urandom_range(0, 131072)) - 65536;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (word_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tdata <= word_queue.pop_front();
        s_tvalid <= 1'b1;
        num_sent++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
  end

  // phase of idling follows progress through the stimulus
  always @(posedge clk) begin
    case ((num_sent * 4) / (num_items + 1))
      0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct <= 55; recv_stall_pct <= 0;  end
      2: begin send_idle_pct <= 0;  recv_stall_pct <= 55; end
      default: begin send_idle_pct <= 17; recv_stall_pct <= 17; end
    endcase
  end

  // monitor
  always @(posedge clk) begin
    logic [33:0] exp_word;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (ff_expected.size() == 0) begin
          $error("unexpected result word %h", m_tdata);
          num_errors++;
        end else begin
          exp_word = ff_expected.pop_front();
          if (m_tdata[31:0] !== exp_word[31:0]) begin
            $error("form_factor expected %h actual %h", exp_word[31:0], m_tdata[31:0]);
            num_errors++;
          end
          if (m_tdata[33:32] !== exp_word[33:32]) begin
            $error("status expected %0d actual %0d", exp_word[33:32], m_tdata[33:32]);
            num_errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        ff_expected.insert(ff_expected.size(), form_factor_of(s_tdata));
    end
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("FAIL hgh_projector_form_factor_core");
      $finish;
    end
  end

  initial begin
    int l, cnt;
    // directed
    add_word(0, 0, 0, 1, 65536, 0, 0);
    add_word(65536, 0, 65536, 3, 65536, -65536, 65536);
    add_word(32768, 1, 98304, 2, -65536, 65536, 0);
    add_word(65536, 2, 131072, 1, 65536, 0, 0);
    add_word(20000, 0, 70000, 0, 1000, 1000, 1000);
    add_word(20000, 3, 70000, 1, 1000, 0, 0);
    add_word(20000, 1, 70000, 3, 1000, 1000, 1000);
    add_word(20000, 2, 70000, 2, 1000, 1000, 0);
    add_word(1048575, 0, 262143, 1, 65536, 0, 0);
    add_word(1048575, 2, 262143, 1, -65536, 0, 0);
    add_word(200000, 0, 131072, 3, 65536, 65536, 65536);
    add_word(1, 1, 1, 2, 65536, 65536, 0);
    add_word(65536, 0, 262143, 3, 131071, -131072, 131071);
    add_word(40000, 2, 262143, 1, 131071, 0, 0);
    add_word(0, 3, 0, 0, 0, 0, 0);
    add_word(8000, 1, 262143, 1, -131072, 0, 0);
    add_word(1048575, 3, 262143, 3, -1, -1, -1);
    for (int k = 0; k < 1300; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        l = $urandom_range(0, 2);
        cnt = $urandom_range(1, 3 - l);
        add_word($urandom_range(0, $urandom_range(0, 1) ? 131071 : 1048575), l,
                 $urandom_range(0, 262143), cnt, rand_weight(), rand_weight(),
                 rand_weight());
      end else begin
        add_word($urandom_range(0, 1048575), $urandom_range(0, 3),
                 $urandom_range(0, 262143), $urandom_range(0, 3),
                 $urandom_range(0, 262143), $urandom_range(0, 262143),
                 $urandom_range(0, 262143));
      end
    end
    num_items = word_queue.size();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (word_queue.size() > 0 || s_tvalid || ff_expected.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (num_errors == 0) $display("PASS hgh_projector_form_factor_core");
    else $display("FAIL hgh_projector_form_factor_core");
    $finish;
  end

endmodule

`default_nettype wire
